// File: sv/stsc_pkg.sv
// Shared types and constants of the slab transport sweep cell.
`default_nettype none
package stsc_pkg;

    localparam int MAX_GROUPS_DEF    = 64;
    localparam int MAX_ORDINATES_DEF = 32;
    localparam int FRAC_BITS_DEF     = 16;

    localparam int QW        = 32;
    localparam int DIV_STEPS = QW;
    localparam int DCW       = $clog2(DIV_STEPS);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CELL = 1'b1;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZDET = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    localparam logic [1:0] CFG_ALB_L   = 2'd0;
    localparam logic [1:0] CFG_ALB_R   = 2'd1;
    localparam logic [1:0] CFG_USE_SRC = 2'd2;
    localparam logic [1:0] CFG_ORD_CNT = 2'd3;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_BMUL, ST_RD, ST_MPSI, ST_MP, ST_MQ1, ST_MQ2,
        ST_COEF, ST_MAA, ST_MMM, ST_M1, ST_M2, ST_M3, ST_M4, ST_SUMS,
        ST_DLD1, ST_DIV1, ST_DEND1, ST_DLD2, ST_DIV2, ST_DEND2, ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_PSI, MUL_P, MUL_Q1, MUL_Q2, MUL_AA, MUL_MM,
        MUL_T1, MUL_T2, MUL_T3, MUL_T4, MUL_B
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     rd;
        logic     clr;
        mul_sel_t mul;
        logic     coef;
        logic     sums;
        logic     div_load;
        logic     div_sel;
        logic     div_step;
        logic     div_end;
        logic     fin;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// File: sv/stsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module stsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: sv/stsc_ctrl.sv
// Sequencer of the sweep cell: table clear, multiply steps and divider passes.
`default_nettype none
module stsc_ctrl #(
    parameter int AW = 11,
    parameter int DEPTH = 2048
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   operation,
    input  wire stsc_pkg::dp_status_t   status,
    output logic                        in_ready,
    output stsc_pkg::cmd_t              cmd,
    output logic [AW-1:0]               clr_addr
);

    stsc_pkg::state_t           state_reg, state_next;
    logic [AW-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [stsc_pkg::DCW-1:0]   div_cnt_reg, div_cnt_next;
    logic                       div_last;

    assign div_last = div_cnt_reg == stsc_pkg::DCW'(stsc_pkg::DIV_STEPS - 1);
    assign clr_addr = clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= stsc_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        div_cnt_next = '0;
        case (state_reg)
            stsc_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = stsc_pkg::ST_IDLE;
                end
            end
            stsc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (operation == stsc_pkg::OP_LOAD) ?
                                 stsc_pkg::ST_BMUL : stsc_pkg::ST_RD;
                end
            end
            stsc_pkg::ST_BMUL:  state_next = stsc_pkg::ST_FIN;
            stsc_pkg::ST_RD:    state_next = stsc_pkg::ST_MPSI;
            stsc_pkg::ST_MPSI:  state_next = stsc_pkg::ST_MP;
            stsc_pkg::ST_MP:    state_next = stsc_pkg::ST_MQ1;
            stsc_pkg::ST_MQ1:   state_next = stsc_pkg::ST_MQ2;
            stsc_pkg::ST_MQ2:   state_next = stsc_pkg::ST_COEF;
            stsc_pkg::ST_COEF:  state_next = stsc_pkg::ST_MAA;
            stsc_pkg::ST_MAA:   state_next = stsc_pkg::ST_MMM;
            stsc_pkg::ST_MMM:   state_next = stsc_pkg::ST_M1;
            stsc_pkg::ST_M1:    state_next = stsc_pkg::ST_M2;
            stsc_pkg::ST_M2:    state_next = stsc_pkg::ST_M3;
            stsc_pkg::ST_M3:    state_next = stsc_pkg::ST_M4;
            stsc_pkg::ST_M4:    state_next = stsc_pkg::ST_SUMS;
            stsc_pkg::ST_SUMS:  state_next = stsc_pkg::ST_DLD1;
            stsc_pkg::ST_DLD1:  state_next = stsc_pkg::ST_DIV1;
            stsc_pkg::ST_DIV1:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = stsc_pkg::ST_DEND1;
                end
            end
            stsc_pkg::ST_DEND1: state_next = stsc_pkg::ST_DLD2;
            stsc_pkg::ST_DLD2:  state_next = stsc_pkg::ST_DIV2;
            stsc_pkg::ST_DIV2:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = stsc_pkg::ST_DEND2;
                end
            end
            stsc_pkg::ST_DEND2: state_next = stsc_pkg::ST_FIN;
            stsc_pkg::ST_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = stsc_pkg::ST_IDLE;
                end
            end
            default:            state_next = stsc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.mul  = stsc_pkg::MUL_NONE;
        in_ready = 1'b0;
        case (state_reg)
            stsc_pkg::ST_CLEAR: cmd.clr = 1'b1;
            stsc_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            stsc_pkg::ST_BMUL:  cmd.mul = stsc_pkg::MUL_B;
            stsc_pkg::ST_RD:    cmd.rd = 1'b1;
            stsc_pkg::ST_MPSI:  cmd.mul = stsc_pkg::MUL_PSI;
            stsc_pkg::ST_MP:    cmd.mul = stsc_pkg::MUL_P;
            stsc_pkg::ST_MQ1:   cmd.mul = stsc_pkg::MUL_Q1;
            stsc_pkg::ST_MQ2:   cmd.mul = stsc_pkg::MUL_Q2;
            stsc_pkg::ST_COEF:  cmd.coef = 1'b1;
            stsc_pkg::ST_MAA:   cmd.mul = stsc_pkg::MUL_AA;
            stsc_pkg::ST_MMM:   cmd.mul = stsc_pkg::MUL_MM;
            stsc_pkg::ST_M1:    cmd.mul = stsc_pkg::MUL_T1;
            stsc_pkg::ST_M2:    cmd.mul = stsc_pkg::MUL_T2;
            stsc_pkg::ST_M3:    cmd.mul = stsc_pkg::MUL_T3;
            stsc_pkg::ST_M4:    cmd.mul = stsc_pkg::MUL_T4;
            stsc_pkg::ST_SUMS:  cmd.sums = 1'b1;
            stsc_pkg::ST_DLD1:  cmd.div_load = 1'b1;
            stsc_pkg::ST_DIV1:  cmd.div_step = 1'b1;
            stsc_pkg::ST_DEND1: cmd.div_end = 1'b1;
            stsc_pkg::ST_DLD2:
            begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = 1'b1;
            end
            stsc_pkg::ST_DIV2:  cmd.div_step = 1'b1;
            stsc_pkg::ST_DEND2:
            begin
                cmd.div_end = 1'b1;
                cmd.div_sel = 1'b1;
            end
            stsc_pkg::ST_FIN:   cmd.fin = status.out_free;
            default:            cmd.clr = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/stsc_dp.sv
// Datapath of the sweep cell: item registers, shared multiplier, divider, flux table.
`default_nettype none
module stsc_dp #(
    parameter int MAX_GROUPS = 64,
    parameter int MAX_ORDINATES = 32,
    parameter int FRAC_BITS = 16,
    parameter int AW = 11
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [16:0]          cfg_data,
    input  wire logic                 operation,
    input  wire logic [5:0]           group,
    input  wire logic [4:0]           ordinate,
    input  wire logic                 side,
    input  wire logic signed [17:0]   mu,
    input  wire logic [30:0]          sigma_total,
    input  wire logic [30:0]          cell_length,
    input  wire logic signed [31:0]   source_node1,
    input  wire logic signed [31:0]   source_node2,
    input  wire logic signed [31:0]   reflected_flux,
    input  wire logic signed [31:0]   boundary_flux,
    input  wire stsc_pkg::cmd_t       cmd,
    input  wire logic [AW-1:0]        clr_addr,
    output stsc_pkg::dp_status_t      dp_status,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        flux_node1,
    output logic signed [31:0]        flux_node2,
    output logic [1:0]                status
);

    localparam int DEPTH = MAX_GROUPS * MAX_ORDINATES;

    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647)
        begin
            r = {1'b1, 32'h7fff_ffff};
        end
        else if (v < -64'sd2147483648)
        begin
            r = {1'b1, 32'h8000_0000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    logic [16:0] alb_l_reg, alb_r_reg;
    logic        use_src_reg;
    logic [5:0]  ord_cnt_reg;

    logic               op_reg, side_reg;
    logic [5:0]         grp_reg;
    logic [4:0]         ord_reg;
    logic signed [17:0] mu_reg;
    logic [30:0]        st_reg, len_reg;
    logic signed [31:0] q1_reg, q2_reg, refl_reg, bflux_reg;

    logic signed [63:0] mp_reg, p_reg, lq1_reg, lq2_reg, aa_reg, mm_reg;
    logic signed [63:0] t1_reg, t2_reg, t3_reg, t4_reg, b_reg, n1_reg, n2_reg;
    logic signed [31:0] a_reg, s1_reg, s2_reg, f1_reg, f2_reg;
    logic [63:0]        det_reg;
    logic               sat_reg, sat_next;

    logic [63:0] rem_reg;
    logic [31:0] dvd_reg, quo_reg;
    logic        neg_reg, ovf_reg;

    logic               out_valid_reg;
    logic signed [31:0] fn1_reg, fn2_reg;
    logic [1:0]         stat_reg;

    logic               idx_ok, right;
    logic [AW-1:0]      addr;
    logic [31:0]        ram_rdata;
    logic signed [31:0] psi;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;

    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;

    logic signed [63:0] mu64, psh, mp2, a_raw, s1_raw, s2_raw;
    logic [32:0]        a_s, s1_s, s2_s;

    logic signed [63:0] n_sel;
    logic [63:0]        mag, top, trial;
    logic               ge;
    logic [31:0]        lim, qv, qres;
    logic               qsat;

    logic signed [63:0] bv;
    logic [32:0]        bs;
    logic               det_zero;
    logic signed [31:0] o1, o2, store;
    logic [1:0]         ost;

    assign idx_ok = (32'(grp_reg) < MAX_GROUPS) && (32'(ord_reg) < MAX_ORDINATES);
    assign addr   = AW'(32'(grp_reg) + MAX_GROUPS * 32'(ord_reg));
    assign right  = {1'b0, ord_reg} >= (ord_cnt_reg >> 1);
    assign psi    = idx_ok ? $signed(ram_rdata) : 32'sd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alb_l_reg   <= '0;
            alb_r_reg   <= '0;
            use_src_reg <= 1'b0;
            ord_cnt_reg <= 6'd2;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                stsc_pkg::CFG_ALB_L:   alb_l_reg   <= cfg_data;
                stsc_pkg::CFG_ALB_R:   alb_r_reg   <= cfg_data;
                stsc_pkg::CFG_USE_SRC: use_src_reg <= cfg_data[0];
                stsc_pkg::CFG_ORD_CNT: ord_cnt_reg <= cfg_data[5:0];
                default:               use_src_reg <= use_src_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            grp_reg   <= group;
            ord_reg   <= ordinate;
            side_reg  <= side;
            mu_reg    <= mu;
            st_reg    <= sigma_total;
            len_reg   <= cell_length;
            q1_reg    <= source_node1;
            q2_reg    <= source_node2;
            refl_reg  <= reflected_flux;
            bflux_reg <= boundary_flux;
        end
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.mul)
            stsc_pkg::MUL_PSI:
            begin
                ma = 33'(mu_reg);
                mb = 33'(psi);
            end
            stsc_pkg::MUL_P:
            begin
                ma = $signed({2'b00, st_reg});
                mb = $signed({2'b00, len_reg});
            end
            stsc_pkg::MUL_Q1:
            begin
                ma = $signed({2'b00, len_reg});
                mb = 33'(q1_reg);
            end
            stsc_pkg::MUL_Q2:
            begin
                ma = $signed({2'b00, len_reg});
                mb = 33'(q2_reg);
            end
            stsc_pkg::MUL_AA:
            begin
                ma = 33'(a_reg);
                mb = 33'(a_reg);
            end
            stsc_pkg::MUL_MM:
            begin
                ma = 33'(mu_reg);
                mb = 33'(mu_reg);
            end
            stsc_pkg::MUL_T1:
            begin
                ma = 33'(a_reg);
                mb = 33'(s1_reg);
            end
            stsc_pkg::MUL_T2:
            begin
                ma = 33'(mu_reg);
                mb = 33'(s2_reg);
            end
            stsc_pkg::MUL_T3:
            begin
                ma = 33'(mu_reg);
                mb = 33'(s1_reg);
            end
            stsc_pkg::MUL_T4:
            begin
                ma = 33'(a_reg);
                mb = 33'(s2_reg);
            end
            stsc_pkg::MUL_B:
            begin
                ma = $signed({16'd0, side_reg ? alb_r_reg : alb_l_reg});
                mb = 33'(refl_reg);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = ma * mb;

    always_ff @(posedge clk)
    begin
        case (cmd.mul)
            stsc_pkg::MUL_PSI: mp_reg  <= prod[63:0];
            stsc_pkg::MUL_P:   p_reg   <= prod[63:0];
            stsc_pkg::MUL_Q1:  lq1_reg <= prod[63:0];
            stsc_pkg::MUL_Q2:  lq2_reg <= prod[63:0];
            stsc_pkg::MUL_AA:  aa_reg  <= prod[63:0];
            stsc_pkg::MUL_MM:  mm_reg  <= prod[63:0];
            stsc_pkg::MUL_T1:  t1_reg  <= prod[63:0];
            stsc_pkg::MUL_T2:  t2_reg  <= prod[63:0];
            stsc_pkg::MUL_T3:  t3_reg  <= prod[63:0];
            stsc_pkg::MUL_T4:  t4_reg  <= prod[63:0];
            stsc_pkg::MUL_B:   b_reg   <= prod[63:0];
            default:           b_reg   <= b_reg;
        endcase
    end

    assign mu64   = 64'(mu_reg);
    assign psh    = p_reg >>> FRAC_BITS;
    assign mp2    = mp_reg <<< 1;
    assign a_raw  = right ? (psh + mu64) : (psh - mu64);
    assign s1_raw = right ? ((lq1_reg + mp2) >>> FRAC_BITS) : (lq1_reg >>> FRAC_BITS);
    assign s2_raw = right ? (lq2_reg >>> FRAC_BITS) : ((lq2_reg - mp2) >>> FRAC_BITS);
    assign a_s    = sat32(a_raw);
    assign s1_s   = sat32(s1_raw);
    assign s2_s   = sat32(s2_raw);

    assign n_sel = cmd.div_sel ? n2_reg : n1_reg;
    assign mag   = (n_sel < 0) ? $unsigned(-n_sel) : $unsigned(n_sel);
    assign top   = mag >> (stsc_pkg::QW - FRAC_BITS);
    assign trial = {rem_reg[62:0], dvd_reg[31]};
    assign ge    = trial >= det_reg;
    assign lim   = neg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
    assign qsat  = ovf_reg || (quo_reg > lim);
    assign qv    = qsat ? lim : quo_reg;
    assign qres  = neg_reg ? (32'd0 - qv) : qv;

    always_ff @(posedge clk)
    begin
        if (cmd.coef)
        begin
            a_reg  <= a_s[31:0];
            s1_reg <= s1_s[31:0];
            s2_reg <= s2_s[31:0];
        end
        if (cmd.sums)
        begin
            det_reg <= $unsigned(aa_reg + mm_reg);
            n1_reg  <= t1_reg - t2_reg;
            n2_reg  <= t3_reg + t4_reg;
        end
        if (cmd.div_load)
        begin
            neg_reg <= n_sel < 0;
            ovf_reg <= top >= det_reg;
            rem_reg <= top;
            dvd_reg <= mag[31:0] << FRAC_BITS;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? (trial - det_reg) : trial;
            dvd_reg <= dvd_reg << 1;
            quo_reg <= {quo_reg[30:0], ge};
        end
        if (cmd.div_end)
        begin
            if (cmd.div_sel)
            begin
                f2_reg <= $signed(qres);
            end
            else
            begin
                f1_reg <= $signed(qres);
            end
        end
    end

    always_comb
    begin
        sat_next = sat_reg;
        if (cmd.capture)
        begin
            sat_next = 1'b0;
        end
        else if (cmd.coef)
        begin
            sat_next = sat_reg | a_s[32] | s1_s[32] | s2_s[32];
        end
        else if (cmd.div_end)
        begin
            sat_next = sat_reg | qsat;
        end
    end

    assign bv       = (b_reg >>> FRAC_BITS) + (use_src_reg ? 64'(bflux_reg) : 64'sd0);
    assign bs       = sat32(bv);
    assign det_zero = det_reg == 64'd0;

    always_comb
    begin
        if (op_reg == stsc_pkg::OP_LOAD)
        begin
            o1    = $signed(bs[31:0]);
            o2    = 32'sd0;
            ost   = bs[32] ? stsc_pkg::STAT_SAT : stsc_pkg::STAT_OK;
            store = o1;
        end
        else if (det_zero)
        begin
            o1    = 32'sd0;
            o2    = 32'sd0;
            ost   = stsc_pkg::STAT_ZDET;
            store = 32'sd0;
        end
        else
        begin
            o1    = f1_reg;
            o2    = f2_reg;
            ost   = sat_reg ? stsc_pkg::STAT_SAT : stsc_pkg::STAT_OK;
            store = right ? f2_reg : f1_reg;
        end
    end

    assign ram_we    = cmd.clr | (cmd.fin & idx_ok);
    assign ram_waddr = cmd.clr ? clr_addr : addr;
    assign ram_wdata = cmd.clr ? 32'd0 : store;

    stsc_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            sat_reg <= sat_next;
            if (cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            fn1_reg  <= o1;
            fn2_reg  <= o2;
            stat_reg <= ost;
        end
    end

    assign dp_status.out_free = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign flux_node1 = fn1_reg;
    assign flux_node2 = fn2_reg;
    assign status     = stat_reg;

endmodule
`default_nettype wire

// File: sv/slab_transport_sweep_cell.sv
// Top level of the slab transport sweep cell: sequencer, datapath and checks.
`default_nettype none
// One item at a time. A boundary load takes one product and is written to the
// result register in ST_FIN; a cell solve reads the table and runs its products,
// coefficients, sums and both divider passes before ST_FIN, which waits for a free
// output register. The cell time is set by the single shared 33x33 multiplier (ten
// products in turn) and the radix-2 divider that runs two 32-step passes, one per
// node flux. After reset the incoming-flux table, MAX_GROUPS*MAX_ORDINATES entries
// (2048 by default), is cleared one entry a cycle while in_ready stays low;
// configuration writes are taken at any time and belong where no item is in flight.
// A finished result waits in an output register while the next item is accepted.
module slab_transport_sweep_cell #(
    parameter int MAX_GROUPS    = stsc_pkg::MAX_GROUPS_DEF,
    parameter int MAX_ORDINATES = stsc_pkg::MAX_ORDINATES_DEF,
    parameter int FRAC_BITS     = stsc_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [16:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               operation,
    input  wire logic [5:0]         group,
    input  wire logic [4:0]         ordinate,
    input  wire logic               side,
    input  wire logic signed [17:0] mu,
    input  wire logic [30:0]        sigma_total,
    input  wire logic [30:0]        cell_length,
    input  wire logic signed [31:0] source_node1,
    input  wire logic signed [31:0] source_node2,
    input  wire logic signed [31:0] reflected_flux,
    input  wire logic signed [31:0] boundary_flux,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      flux_node1,
    output logic signed [31:0]      flux_node2,
    output logic [1:0]              status
);

    localparam int DEPTH = MAX_GROUPS * MAX_ORDINATES;
    localparam int AW    = $clog2(DEPTH);

    stsc_pkg::cmd_t       cmd;
    stsc_pkg::dp_status_t dp_status;
    logic [AW-1:0]        clr_addr;

    assign cfg_ready = 1'b1;

    stsc_ctrl #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .status    (dp_status),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .clr_addr  (clr_addr)
    );

    stsc_dp #(
        .MAX_GROUPS    (MAX_GROUPS),
        .MAX_ORDINATES (MAX_ORDINATES),
        .FRAC_BITS     (FRAC_BITS),
        .AW            (AW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .group          (group),
        .ordinate       (ordinate),
        .side           (side),
        .mu             (mu),
        .sigma_total    (sigma_total),
        .cell_length    (cell_length),
        .source_node1   (source_node1),
        .source_node2   (source_node2),
        .reflected_flux (reflected_flux),
        .boundary_flux  (boundary_flux),
        .cmd            (cmd),
        .clr_addr       (clr_addr),
        .dp_status      (dp_status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .flux_node1     (flux_node1),
        .flux_node2     (flux_node2),
        .status         (status)
    );

    a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == stsc_pkg::STAT_OK || status == stsc_pkg::STAT_ZDET ||
                       status == stsc_pkg::STAT_SAT))
        else $error("invalid status code");

    a_zdet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == stsc_pkg::STAT_ZDET) |->
        (flux_node1 == 32'sd0 && flux_node2 == 32'sd0))
        else $error("zero determinant with nonzero flux");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while busy");

endmodule
`default_nettype wire
